// File: hw/rtl/disk_mesh_reference_to_physical_map_core_defines.svh
// Assertion macros for the disk mesh map core.
`ifndef DISK_MESH_REFERENCE_TO_PHYSICAL_MAP_CORE_DEFINES_SVH
`define DISK_MESH_REFERENCE_TO_PHYSICAL_MAP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMRPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DMRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dmrpm_pkg.sv
// Package: constants, codes and types of the disk mesh map core.
package dmrpm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 24;
  localparam int REF_W     = FRAC_BITS + 1;
  localparam int OUT_W     = 25;
  localparam int YBAR_W    = REF_W + 2;
  localparam int T_W       = 36;
  localparam int SQ_STEPS  = 18;
  localparam int Q_W       = 18;
  localparam int C_W       = 17;
  localparam int DIV_STEPS = C_W;
  localparam int P_W       = 25;
  localparam int X_W       = 30;
  localparam int Y_W       = 34;

  // round(2^32 / sqrt(2))
  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

  // Patch codes
  localparam logic [2:0] TREE_BOTTOM = 3'd0;
  localparam logic [2:0] TREE_LEFT   = 3'd1;
  localparam logic [2:0] TREE_CENTER = 3'd2;
  localparam logic [2:0] TREE_RIGHT  = 3'd3;
  localparam logic [2:0] TREE_TOP    = 3'd4;

  // Register indexes
  localparam logic CFG_R_INNER = 1'b0;
  localparam logic CFG_R_OUTER = 1'b1;

  // Per-item side data carried down the pipeline
  typedef struct packed {
    logic [2:0]               tree;
    logic [REF_W-1:0]         a;
    logic [REF_W-1:0]         b;
    logic signed [YBAR_W-1:0] ybar;
  } sb_t;

endpackage

// File: hw/rtl/disk_mesh_reference_to_physical_map_core.sv
// Throughput: one item per cycle while the output is not stalled; 18 square-root
// steps and 17 divide steps each hold one register stage, so the pipeline depth
// sets the latency.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (rst, synchronous) clears all valid bits and loads r_inner = 1.0,
// r_outer = 2.0.
module disk_mesh_reference_to_physical_map_core
  import dmrpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // ref_x[16:0], ref_y[33:17], zero fill
  input  logic [2:0]  s_tuser,   // tree_index[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_x[24:0], out_y[49:25], zero fill
  output logic [0:0]  m_tuser    // bad_tree[0]
);

`include "disk_mesh_reference_to_physical_map_core_defines.svh"

  localparam int NST   = 42;
  localparam int ST_T  = 1;
  localparam int ST_DV = ST_T + SQ_STEPS + 1;
  localparam int ST_P  = ST_DV + DIV_STEPS + 1;
  localparam int ST_X  = ST_P + 1;
  localparam int ST_Y  = ST_X + 1;
  localparam int ST_O  = ST_Y + 1;
  localparam logic [Y_W+15:0] HALF_Y = (Y_W+16)'(1) << (FRAC_BITS - 1);

  // Configuration registers and derived square half-width
  logic [REG_W-1:0] r_inner, r_outer;
  logic [REG_W-1:0] s_half;
  logic [55:0]      s_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_inner <= REG_W'(65536);
      r_outer <= REG_W'(131072);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_R_INNER: r_inner <= cfg_data;
        CFG_R_OUTER: r_outer <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_prod = 56'(r_inner) * 56'(INV_SQRT2_Q32) + (56'd1 << 31);

  always_ff @(posedge clk) begin
    s_half <= s_prod[55:32];
  end

  // Pipeline control: all stages move together
  logic            en;
  logic [NST-1:0]  vld;
  sb_t             sb [NST];

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // Stage 0: pick radial / tangential coordinates, form ybar
  logic [REF_W-1:0] in_rx, in_ry;
  logic             in_swap;
  sb_t              in_sb;

  assign in_rx   = s_tdata[REF_W-1:0];
  assign in_ry   = s_tdata[2*REF_W-1:REF_W];
  assign in_swap = (s_tuser == TREE_BOTTOM) || (s_tuser == TREE_TOP);

  always_comb begin
    in_sb.tree = s_tuser;
    in_sb.a    = in_swap ? in_ry : in_rx;
    in_sb.b    = in_swap ? in_rx : in_ry;
    in_sb.ybar = $signed({1'b0, in_sb.b, 1'b0}) - $signed(YBAR_W'(65536));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= in_sb;
      for (int i = 1; i < NST; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // Stage 1: t = 1 + ybar^2
  logic signed [2*YBAR_W-1:0] ysq;
  logic [T_W-1:0] sq_n [SQ_STEPS+1];
  logic [T_W-1:0] sq_r [SQ_STEPS+1];

  assign ysq = sb[0].ybar * sb[0].ybar;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0] <= (T_W'(1) << (2*FRAC_BITS)) + ysq[T_W-1:0];
      sq_r[0] <= '0;
    end
  end

  // Square root: one bit pair per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [T_W-1:0] BITK = T_W'(1) << (2*(SQ_STEPS-1-k));
    logic [T_W-1:0] trial;
    assign trial = sq_r[k] + BITK;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_n[k] >= trial) begin
          sq_n[k+1] <= sq_n[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BITK;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // Divide (2^32 + q/2) / q: one quotient bit per stage
  logic [Q_W-1:0]   dv_q   [DIV_STEPS+1];
  logic [Q_W-1:0]   dv_rem [DIV_STEPS+1];
  logic [C_W-1:0]   dv_quo [DIV_STEPS+1];
  logic [C_W-1:0]   dv_nlo [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_q[0]   <= sq_r[SQ_STEPS][Q_W-1:0];
      dv_rem[0] <= Q_W'(1) << (2*FRAC_BITS - C_W);
      dv_quo[0] <= '0;
      dv_nlo[0] <= sq_r[SQ_STEPS][Q_W-1:1];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [Q_W:0] tr;
    logic         ge;
    assign tr = {dv_rem[j], dv_nlo[j][C_W-1-j]};
    assign ge = (tr >= {1'b0, dv_q[j]});
    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j+1]   <= dv_q[j];
        dv_nlo[j+1] <= dv_nlo[j];
        dv_quo[j+1] <= {dv_quo[j][C_W-2:0], ge};
        dv_rem[j+1] <= ge ? Q_W'(tr - {1'b0, dv_q[j]}) : tr[Q_W-1:0];
      end
    end
  end

  // Circle point P = r_outer * c
  logic [REG_W+C_W-1:0] p_prod;
  logic [P_W-1:0]       p_rad;

  assign p_prod = (REG_W+C_W)'(r_outer) * (REG_W+C_W)'(dv_quo[DIV_STEPS])
                  + ((REG_W+C_W)'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      p_rad <= p_prod[REG_W+C_W-1:FRAC_BITS];
    end
  end

  // Blend between square edge and circle
  logic                low_side, is_center;
  logic signed [25:0]  lo, hi;
  logic signed [26:0]  diff;
  logic signed [44:0]  prod_a, prod_b;
  logic signed [X_W-1:0] x_blend, yc_blend;
  logic signed [X_W-1:0] x_reg, yc_reg;

  assign is_center = (sb[ST_P].tree == TREE_CENTER);
  assign low_side  = (sb[ST_P].tree inside {TREE_BOTTOM, TREE_LEFT});

  always_comb begin
    if (is_center) begin
      lo = -$signed({2'b00, s_half});
      hi = $signed({2'b00, s_half});
    end else if (low_side) begin
      lo = -$signed({1'b0, p_rad});
      hi = -$signed({2'b00, s_half});
    end else begin
      lo = $signed({2'b00, s_half});
      hi = $signed({1'b0, p_rad});
    end
    diff     = 27'(hi) - 27'(lo);
    prod_a   = 45'(diff) * 45'($signed({1'b0, sb[ST_P].a}))
               + 45'(65'd1 << (FRAC_BITS - 1));
    prod_b   = 45'(diff) * 45'($signed({1'b0, sb[ST_P].b}))
               + 45'(65'd1 << (FRAC_BITS - 1));
    x_blend  = X_W'(lo) + X_W'(prod_a >>> FRAC_BITS);
    yc_blend = X_W'(lo) + X_W'(prod_b >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_reg  <= x_blend;
      yc_reg <= yc_blend;
    end
  end

  // Y = X * ybar, or the centre-square y
  logic signed [X_W+YBAR_W-1:0] y_prod;
  logic signed [Y_W-1:0]        y_reg;

  assign y_prod = (X_W+YBAR_W)'(x_reg) * (X_W+YBAR_W)'(sb[ST_X].ybar)
                  + $signed((X_W+YBAR_W)'(HALF_Y));

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb[ST_X].tree == TREE_CENTER) begin
        y_reg <= Y_W'(yc_reg);
      end else begin
        y_reg <= Y_W'(y_prod >>> FRAC_BITS);
      end
    end
  end

  logic signed [X_W-1:0] x_d;
  always_ff @(posedge clk) begin
    if (en) begin
      x_d <= x_reg;
    end
  end

  // Orientation, saturation and error flag
  function automatic logic [OUT_W-1:0] sat(input logic signed [Y_W-1:0] v);
    logic signed [Y_W-1:0] vmax, vmin;
    vmax = Y_W'(16777215);
    vmin = -Y_W'(16777216);
    if (v > vmax) begin
      sat = OUT_W'(vmax);
    end else if (v < vmin) begin
      sat = OUT_W'(vmin);
    end else begin
      sat = OUT_W'(v);
    end
  endfunction

  logic                  o_low, o_swap, o_bad;
  logic signed [Y_W-1:0] yn, ox, oy;
  logic [OUT_W-1:0]      out_x, out_y;
  logic                  bad_tree;

  assign o_low  = (sb[ST_Y].tree inside {TREE_BOTTOM, TREE_LEFT});
  assign o_swap = (sb[ST_Y].tree inside {TREE_BOTTOM, TREE_TOP});
  assign o_bad  = (sb[ST_Y].tree > TREE_TOP);

  always_comb begin
    yn = o_low ? -y_reg : y_reg;
    ox = o_swap ? yn : Y_W'(x_d);
    oy = o_swap ? Y_W'(x_d) : yn;
    if (o_bad) begin
      ox = '0;
      oy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= sat(ox);
      out_y    <= sat(oy);
      bad_tree <= o_bad;
    end
  end

  assign m_tvalid = vld[ST_O];
  assign m_tdata  = {6'd0, out_y, out_x};
  assign m_tuser  = bad_tree;

  // Checks
  `DMRPM_ASSERT_NOW(a_bad_zero, m_tvalid && m_tuser[0], m_tdata == 56'd0,
    "bad patch result is not zero")
  `DMRPM_ASSERT_NOW(a_root_ge_one, vld[ST_DV], dv_q[0] >= Q_W'(65536),
    "square root below one")
  `DMRPM_ASSERT_NOW(a_quo_le_one, vld[ST_P - 1] && (ST_P - 1 == ST_DV + DIV_STEPS),
    dv_quo[DIV_STEPS] <= C_W'(65536), "blend factor above one")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the five-patch disk reference-to-physical map core.
`timescale 1ns / 100ps

module testbench
  import dmrpm_pkg::*;
();

  typedef struct {
    logic signed [24:0] px;
    logic signed [24:0] py;
    logic               bad;
  } point_t;

  // Scoreboard: predicts each mapped point and checks results in order
  class disk_map_board;
    longint unsigned r_inner = 65536;
    longint unsigned r_outer = 131072;
    point_t          pending_pts[$];
    int              fails = 0;

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // round half up on a signed Q.F product
    function longint round_q(longint v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function logic signed [24:0] clamp(longint v);
      if (v > 16777215) v = 16777215;
      if (v < -16777216) v = -16777216;
      return v[24:0];
    endfunction

    function void note_input(logic [2:0] tree, logic [16:0] rx, logic [16:0] ry);
      longint unsigned one_sq, t, q, c, half_w;
      longint s, x, y, a, b, ybar, p, lo, hi, xr, yr;
      bit swap, low_side;
      point_t e;
      one_sq = 64'd1 << (2 * FRAC_BITS);
      half_w = (r_inner * INV_SQRT2_Q32 + (64'd1 << 31)) >> 32;
      s = half_w;
      x = 0;
      y = 0;
      e.bad = 1'b0;
      if (tree == TREE_CENTER) begin
        x = -s + longint'((longint'(2 * s * rx) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        y = -s + longint'((longint'(2 * s * ry) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      end else if (tree <= TREE_TOP) begin
        swap = (tree == TREE_BOTTOM || tree == TREE_TOP);
        low_side = (tree == TREE_BOTTOM || tree == TREE_LEFT);
        a = swap ? ry : rx;
        b = swap ? rx : ry;
        ybar = 2 * b - (64'sd1 <<< FRAC_BITS);
        t = one_sq + longint'(ybar * ybar);
        q = int_sqrt(t);
        c = (one_sq + (q >> 1)) / q;
        p = (r_outer * c + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lo = low_side ? -p : s;
        hi = low_side ? -s : p;
        xr = lo + round_q((hi - lo) * a);
        yr = round_q(xr * ybar);
        if (low_side) yr = -yr;
        if (swap) begin
          y = xr;
          x = yr;
        end else begin
          x = xr;
          y = yr;
        end
      end else begin
        e.bad = 1'b1;
      end
      e.px = clamp(x);
      e.py = clamp(y);
      pending_pts.push_back(e);
    endfunction

    function void check_result(logic signed [24:0] gx, logic signed [24:0] gy, logic gbad);
      point_t e;
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d bad=%0d", $time, gx, gy, gbad);
        fails++;
        return;
      end
      e = pending_pts.pop_front();
      if (gx !== e.px) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.px, gx);
        fails++;
      end
      if (gy !== e.py) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.py, gy);
        fails++;
      end
      if (gbad !== e.bad) begin
        $display("%0t: bad_tree expected %0d actual %0d", $time, e.bad, gbad);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_R_INNER;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // ref_x[16:0], ref_y[33:17], zero fill
  logic [2:0]  s_tuser = '0;   // tree_index[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // out_x[24:0], out_y[49:25], zero fill
  logic [0:0]  m_tuser;        // bad_tree[0]

  disk_map_board board = new();
  bit            long_hold = 1'b0;
  bit            no_idle = 1'b0;
  int            cycle_count = 0;

  disk_mesh_reference_to_physical_map_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitor both handshakes
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      board.note_input(s_tuser, s_tdata[16:0], s_tdata[33:17]);
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tdata[24:0], m_tdata[49:25], m_tuser[0]);
  end

  function int draw_gap();
    if (no_idle) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  // Receiver: random stalls per item, plus one long hold-off on request
  initial begin : receiver
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_point(logic [2:0] tree, logic [16:0] rx, logic [16:0] ry);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tree;
    s_tdata  <= {6'b0, ry, rx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait for all results, then for the pipeline depth
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_R_INNER) board.r_inner = val;
    else board.r_outer = val;
  endtask

  function logic [16:0] rand_ref();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_points(int n);
    logic [2:0] tree;
    repeat (n) begin
      tree = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
      send_point(tree, rand_ref(), rand_ref());
    end
  endtask

  initial begin : stimulus
    logic [16:0] corners [4];
    corners = '{17'd0, 17'd32768, 17'd65536, 17'd131071};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every patch at the corners, invalid patches, extrapolation
    for (int t = 0; t < 8; t++) begin
      send_point(t[2:0], corners[0], corners[2]);
      send_point(t[2:0], corners[2], corners[3]);
      send_point(t[2:0], corners[3], corners[1]);
    end
    drain();

    // Reset radii, then a long receiver hold-off with back-to-back input
    random_points(200);
    drain();
    no_idle = 1'b1;
    long_hold = 1'b1;
    random_points(150);
    no_idle = 1'b0;
    drain();

    // Zero radii
    write_reg(CFG_R_INNER, 24'd0);
    write_reg(CFG_R_OUTER, 24'd0);
    random_points(150);
    drain();

    // Largest radii: outputs saturate
    write_reg(CFG_R_INNER, 24'hFFFFFF);
    write_reg(CFG_R_OUTER, 24'hFFFFFF);
    random_points(150);
    drain();

    // Degenerate: outer radius below the square half-width
    write_reg(CFG_R_OUTER, 24'h000100);
    random_points(150);
    drain();

    // Random settings with stretches of no idling
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_R_INNER, 24'($urandom_range(0, 24'h1FFFFF)));
      write_reg(CFG_R_OUTER, 24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                             : $urandom_range(0, 24'h3FFFFF)));
      no_idle = (ph % 3 == 0);
      random_points(120);
      no_idle = 1'b0;
      drain();
    end

    if (board.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: disk_mesh_reference_to_physical_map_core.f
+incdir+hw/rtl
hw/rtl/dmrpm_pkg.sv
hw/rtl/disk_mesh_reference_to_physical_map_core.sv
tb/sv/testbench.sv
